FILE: src/dmt_pkg.sv
// Package with the shared constants, types and helper functions of the deadman timer controller.
package dmt_pkg;

   localparam int WINDOW_LEN = 5;
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int MINCNT_W = 3;
   localparam int CMP_W = (CNT_W > MINCNT_W) ? CNT_W : MINCNT_W;
   localparam int TIMER_W = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USED_W = 37;

   localparam logic [CSR_ADDR_W-1:0] CSR_INITIAL_SECONDS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INCREMENT_SECONDS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ABSENCE_LIMIT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESENCE_MIN_COUNT = 2'd3;

   localparam logic [TIMER_W-1:0] INITIAL_SECONDS_RESET = 16'd80;
   localparam logic [TIMER_W-1:0] INCREMENT_SECONDS_RESET = 16'd600;
   localparam logic [TIMER_W-1:0] ABSENCE_LIMIT_RESET = 16'd30;
   localparam logic [MINCNT_W-1:0] PRESENCE_MIN_COUNT_RESET = 3'd1;

   localparam logic [2:0] MODE_CODE_START = 3'd0;
   localparam logic [2:0] MODE_CODE_RESUME = 3'd1;
   localparam logic [2:0] MODE_CODE_MINUTES = 3'd2;
   localparam logic [2:0] MODE_CODE_SECONDS = 3'd3;
   localparam logic [2:0] MODE_CODE_STOP = 3'd4;

   localparam int SECS_PER_MIN = 60;
   localparam int DISPLAY_MAX = 99;
   localparam int MIN_SAT = DISPLAY_MAX * SECS_PER_MIN;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_MIN = (2 ** RECIP_SHIFT) / SECS_PER_MIN + 1;
   localparam int TLOW_W = 13;
   localparam int PROD_W = 28;

   localparam logic [7:0] DP_BIT = 8'b1000_0000;
   localparam logic [7:0] PAT_ZERO = 8'h3f;
   localparam logic [7:0] PAT_BLANK = 8'h00;

   typedef enum logic [4:0] {
      M_START   = 5'b00001,
      M_RESUME  = 5'b00010,
      M_MINUTES = 5'b00100,
      M_SECONDS = 5'b01000,
      M_STOP    = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [7:0] units;
      logic [7:0] tens;
   } seg_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      case (m)
         M_START:   code = MODE_CODE_START;
         M_RESUME:  code = MODE_CODE_RESUME;
         M_MINUTES: code = MODE_CODE_MINUTES;
         M_SECONDS: code = MODE_CODE_SECONDS;
         M_STOP:    code = MODE_CODE_STOP;
         default:   code = MODE_CODE_START;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] digit_pattern(input logic [3:0] d);
      logic [7:0] pat;
      case (d)
         4'd0:    pat = 8'h3f;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5b;
         4'd3:    pat = 8'h4f;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6d;
         4'd6:    pat = 8'h7d;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7f;
         4'd9:    pat = 8'h67;
         default: pat = PAT_BLANK;
      endcase
      return pat;
   endfunction

endpackage

FILE: src/dmt_display.sv
// Two-digit seven-segment pattern generator for the minutes, seconds and stop modes.
module dmt_display (
   input  dmt_pkg::mode_type           mode,
   input  logic [dmt_pkg::TIMER_W-1:0] timer,
   output dmt_pkg::seg_type            seg
);
   import dmt_pkg::*;

   logic [TLOW_W-1:0] t_low;
   logic [PROD_W-1:0] prod;
   logic [6:0]        min_val;
   logic [6:0]        sec_val;
   logic [6:0]        show_val;
   logic [3:0]        tens;
   logic [3:0]        units;
   logic              dp;
   logic              suppress;
   logic              blank;

   // Minutes come from a reciprocal multiply; the saturation point keeps the operand narrow.
   assign t_low = timer[TLOW_W-1:0];
   assign prod = PROD_W'(t_low) * PROD_W'(RECIP_MIN);
   assign min_val = (timer >= TIMER_W'(MIN_SAT)) ? 7'(DISPLAY_MAX) : 7'(prod >> RECIP_SHIFT);
   assign sec_val = (timer > TIMER_W'(DISPLAY_MAX)) ? 7'(DISPLAY_MAX) : timer[6:0];

   always_comb begin
      show_val = 7'd0;
      dp = 1'b0;
      suppress = 1'b0;
      blank = 1'b0;
      case (mode)
         M_MINUTES: begin
            show_val = min_val;
            dp = timer[0];
            suppress = 1'b1;
         end
         M_SECONDS: begin
            show_val = sec_val;
         end
         M_STOP: begin
            blank = ~timer[0];
         end
         default: begin
            show_val = 7'd0;
         end
      endcase
   end

   always_comb begin
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (show_val >= 7'(10 * k)) begin
            tens = 4'(k);
         end
      end
      units = 4'(show_val - 7'(tens * 4'd10));
   end

   always_comb begin
      if (blank) begin
         seg.units = PAT_BLANK;
         seg.tens = PAT_BLANK;
      end else begin
         seg.units = digit_pattern(units) | (dp ? DP_BIT : PAT_BLANK);
         seg.tens = (suppress && tens == 4'd0) ? PAT_BLANK : digit_pattern(tens);
      end
   end

endmodule

FILE: src/deadman_timer_controller.sv
// Latency: a result appears in the cycle after its request transfer, from the result register.
// Throughput: one request per cycle; the result register stalls intake only while it is full
// and rsp_tready is low.
// Reset: synchronous, active high; it restores all configuration registers to their defaults,
// puts the controller in start mode with a zero timer, clears the presence window and the
// occupancy state, arms the button and shows "00".
module deadman_timer_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: action, pir_sample, zero fill.
   input  logic [dmt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0 up: load_drive, seg_units, seg_tens, mode_now, seconds_left, occupied,
   // zero fill.
   output logic [dmt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [dmt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [dmt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dmt_pkg::*;

   logic [TIMER_W-1:0]    initial_seconds_ff;
   logic [TIMER_W-1:0]    increment_seconds_ff;
   logic [TIMER_W-1:0]    absence_limit_ff;
   logic [MINCNT_W-1:0]   presence_min_count_ff;

   mode_type              mode_ff, mode_in;
   logic [TIMER_W-1:0]    timer_ff, timer_in;
   logic [WINDOW_LEN-1:0] window_ff, window_in;
   logic [TIMER_W-1:0]    absence_ff, absence_in;
   logic                  occupied_ff, occupied_in;
   logic                  load_en_ff, load_en_in;
   logic                  armed_ff, armed_in;
   logic [7:0]            units_ff, units_in;
   logic [7:0]            tens_ff, tens_in;
   logic                  relay_ff, relay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  action;
   logic                  pir_sample;
   logic [WINDOW_LEN-1:0] tick_window;
   logic [CNT_W-1:0]      ones;
   logic                  present;
   logic [TIMER_W-1:0]    tick_timer;
   mode_type              tick_mode;
   seg_type               seg;

   assign action = req_tdata[0];
   assign pir_sample = req_tdata[1];
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept = req_tvalid & req_tready;

   assign tick_window = (window_ff << 1) | WINDOW_LEN'(pir_sample);
   assign ones = CNT_W'($countones(tick_window));
   assign present = CMP_W'(ones) >= CMP_W'(presence_min_count_ff);

   // The start mode loads the timer; it and the resume mode both fall through to minutes.
   always_comb begin
      tick_timer = timer_ff - 16'd1;
      tick_mode = mode_ff;
      if (mode_ff == M_START) begin
         tick_timer = initial_seconds_ff;
         tick_mode = M_MINUTES;
      end else if (mode_ff == M_RESUME) begin
         tick_mode = M_MINUTES;
      end
   end

   dmt_display u_display (
      .mode  (tick_mode),
      .timer (tick_timer),
      .seg   (seg)
   );

   always_comb begin
      mode_in = mode_ff;
      timer_in = timer_ff;
      window_in = window_ff;
      absence_in = absence_ff;
      occupied_in = occupied_ff;
      load_en_in = load_en_ff;
      armed_in = armed_ff;
      units_in = units_ff;
      tens_in = tens_ff;
      relay_in = relay_ff;
      if (accept) begin
         if (action) begin
            if (armed_ff) begin
               timer_in = timer_ff + increment_seconds_ff;
               armed_in = 1'b0;
               mode_in = M_RESUME;
            end
         end else begin
            window_in = tick_window;
            if (occupied_ff) begin
               if (!present) begin
                  if (absence_ff != '1) begin
                     absence_in = absence_ff + 16'd1;
                  end
                  if (absence_in > absence_limit_ff) begin
                     occupied_in = 1'b0;
                  end
               end
            end else if (present) begin
               occupied_in = 1'b1;
               absence_in = '0;
            end
            relay_in = load_en_ff & occupied_in;

            timer_in = tick_timer;
            mode_in = tick_mode;
            units_in = seg.units;
            tens_in = seg.tens;
            if (mode_ff == M_START || mode_ff == M_RESUME) begin
               load_en_in = 1'b1;
               armed_in = 1'b1;
            end
            case (tick_mode)
               M_MINUTES: begin
                  if (tick_timer < TIMER_W'(SECS_PER_MIN)) begin
                     mode_in = M_SECONDS;
                  end
               end
               M_SECONDS: begin
                  if (tick_timer == '0) begin
                     mode_in = M_STOP;
                  end
               end
               M_STOP: begin
                  load_en_in = 1'b0;
               end
               default: begin
                  mode_in = tick_mode;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {(RSP_DATA_W - RSP_USED_W)'(0), occupied_in, timer_in,
                        mode_code(mode_in), tens_in, units_in, relay_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_seconds_ff <= INITIAL_SECONDS_RESET;
         increment_seconds_ff <= INCREMENT_SECONDS_RESET;
         absence_limit_ff <= ABSENCE_LIMIT_RESET;
         presence_min_count_ff <= PRESENCE_MIN_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_INITIAL_SECONDS:    initial_seconds_ff <= csr_wdata;
            CSR_INCREMENT_SECONDS:  increment_seconds_ff <= csr_wdata;
            CSR_ABSENCE_LIMIT:      absence_limit_ff <= csr_wdata;
            CSR_PRESENCE_MIN_COUNT: presence_min_count_ff <= csr_wdata[MINCNT_W-1:0];
            default: begin
               initial_seconds_ff <= initial_seconds_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_START;
         timer_ff <= '0;
         window_ff <= '0;
         absence_ff <= '0;
         occupied_ff <= 1'b0;
         load_en_ff <= 1'b0;
         armed_ff <= 1'b1;
         units_ff <= PAT_ZERO;
         tens_ff <= PAT_ZERO;
         relay_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         timer_ff <= timer_in;
         window_ff <= window_in;
         absence_ff <= absence_in;
         occupied_ff <= occupied_in;
         load_en_ff <= load_en_in;
         armed_ff <= armed_in;
         units_ff <= units_in;
         tens_ff <= tens_in;
         relay_ff <= relay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

FILE: src/dmt_checker.sv
// Port-level checker for the deadman timer controller and its bind to the top level.
module dmt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [dmt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dmt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                             csr_we,
   input logic [dmt_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input logic [dmt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dmt_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_we, csr_addr, csr_wdata};

   // A result that is not taken stays in place unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or vanished");

   // Every request transfer produces a result in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request transfer gave no result");

   // An empty result register never blocks a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("intake stalled with an empty result register");

   // The relay is driven only while the room counts as occupied.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[36])
      else $error("relay driven without occupancy");

endmodule

bind deadman_timer_controller dmt_checker u_dmt_checker (.*);
